// ===== design/cvrpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cvrpc_pkg
// Shared types, constants and the CRC-15 table function for the cell voltage
// readback checker.
// ----------------------------------------------------------------------------
package cvrpc_pkg;

	// CRC-15 packet error code polynomial and seed.
	localparam logic [15:0] PEC_POLY = 16'h4599;
	localparam logic [15:0] PEC_SEED = 16'd16;

	// Byte positions inside one chip's eight-byte frame.
	localparam logic [2:0] POS_PEC_HIGH = 3'd6;
	localparam logic [2:0] POS_PEC_LOW  = 3'd7;

	// Configuration register indexes.
	localparam logic REG_CHIP_COUNT = 1'b0;

	// Result kinds.
	localparam logic KIND_CELL = 1'b0;
	localparam logic KIND_PEC  = 1'b1;

	// One result item.
	typedef struct packed {
		logic        kind;
		logic [3:0]  chip_index;
		logic [3:0]  cell_index;
		logic [15:0] cell_code;
		logic        pec_ok;
		logic        any_error;
		logic        last;
	} result_t;

	// One entry of the byte-wise CRC-15 table, built from the polynomial.
	function automatic logic [15:0] pec_entry(input logic [7:0] idx);
		logic [15:0] r;
		r = {1'b0, idx, 7'b0};
		for (int b = 0; b < 8; b++) begin
			if (r[14]) begin
				r = {r[14:0], 1'b0} ^ PEC_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

	// Advance the remainder by one data byte.
	function automatic logic [15:0] pec_update(input logic [15:0] rem, input logic [7:0] data);
		logic [7:0] addr;
		addr = rem[14:7] ^ data;
		return {rem[7:0], 8'h00} ^ pec_entry(addr);
	endfunction

endpackage

// ===== design/cvrpc_cfg.sv =====
// ----------------------------------------------------------------------------
// cvrpc_cfg
// APB-style register port holding the chip count of the daisy chain.
// ----------------------------------------------------------------------------
module cvrpc_cfg
	import cvrpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [4:0]  chip_count
);

	logic [4:0] chip_count_q;
	logic       reg_index;

	assign reg_index = paddr[2];
	assign pready    = 1'b1;

	// Register write on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_count_q <= 5'd1;
		end else if (psel && penable && pwrite && (reg_index == REG_CHIP_COUNT)) begin
			chip_count_q <= pwdata[4:0];
		end
	end

	// Read back.
	always_comb begin
		unique case (reg_index)
			REG_CHIP_COUNT: prdata = {27'b0, chip_count_q};
			default:        prdata = 32'b0;
		endcase
	end

	assign chip_count = chip_count_q;

endmodule

// ===== design/cvrpc_parse.sv =====
// ----------------------------------------------------------------------------
// cvrpc_parse
// Frame parser: byte position, chip counter, CRC remainder and error flag,
// with the combinational step logic that forms at most one result per byte.
// ----------------------------------------------------------------------------
module cvrpc_parse
	import cvrpc_pkg::*;
#(
	parameter int MAX_CHIPS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  logic       first_byte,
	input  logic [1:0] register_group,
	input  logic [4:0] chip_count,
	output logic       res_valid,
	output result_t    res
);

	localparam int          LIM_INT = (MAX_CHIPS < 16) ? MAX_CHIPS : 16;
	localparam logic [4:0]  LIM     = 5'(LIM_INT);

	logic [2:0]  pos_q;
	logic [3:0]  chip_q;
	logic [7:0]  hold_q;
	logic [15:0] crc_q;
	logic        err_q;
	logic [1:0]  group_q;
	logic        done_q;

	logic [2:0]  pos0, pos_d;
	logic [3:0]  chip0, chip_d;
	logic [15:0] crc0, crc_d;
	logic        err0, err_d;
	logic [1:0]  group0;
	logic        done0, done_d;
	logic [7:0]  hold_d;
	logic [4:0]  eff_chips;
	logic        is_last;
	logic        pec_match;
	logic [15:0] received;

	// Effective chain length: zero counts as one, large values saturate.
	always_comb begin
		if (chip_count == 5'd0) begin
			eff_chips = 5'd1;
		end else if (chip_count > LIM) begin
			eff_chips = LIM;
		end else begin
			eff_chips = chip_count;
		end
	end

	// A first byte restarts the frame before the byte itself is parsed.
	always_comb begin
		pos0   = first_byte ? 3'd0 : pos_q;
		chip0  = first_byte ? 4'd0 : chip_q;
		crc0   = first_byte ? PEC_SEED : crc_q;
		done0  = first_byte ? 1'b0 : done_q;
		group0 = first_byte ? register_group : group_q;
		err0   = (first_byte && (register_group == 2'd0)) ? 1'b0 : err_q;
	end

	assign received  = {hold_q, rx_byte};
	assign pec_match = (received == {crc0[14:0], 1'b0});
	assign is_last   = ({1'b0, chip0} + 5'd1) >= eff_chips;

	// Step logic for one byte.
	always_comb begin
		pos_d     = pos0;
		chip_d    = chip0;
		crc_d     = crc0;
		err_d     = err0;
		done_d    = done0;
		hold_d    = hold_q;
		res_valid = 1'b0;
		res       = '0;
		res.any_error = err0;
		if (!done0) begin
			if (pos0 < POS_PEC_HIGH) begin
				crc_d = pec_update(crc0, rx_byte);
				pos_d = pos0 + 3'd1;
				if (!pos0[0]) begin
					hold_d = rx_byte;
				end else begin
					res_valid      = 1'b1;
					res.kind       = KIND_CELL;
					res.chip_index = chip0;
					res.cell_index = ({2'b0, group0} * 4'd3) + {2'b0, pos0[2:1]};
					res.cell_code  = {rx_byte, hold_q};
				end
			end else if (pos0 == POS_PEC_HIGH) begin
				hold_d = rx_byte;
				pos_d  = POS_PEC_LOW;
			end else begin
				err_d          = err0 | ~pec_match;
				res_valid      = 1'b1;
				res.kind       = KIND_PEC;
				res.chip_index = chip0;
				res.pec_ok     = pec_match;
				res.any_error  = err0 | ~pec_match;
				res.last       = is_last;
				pos_d          = 3'd0;
				crc_d          = PEC_SEED;
				if (is_last) begin
					done_d = 1'b1;
				end else begin
					chip_d = chip0 + 4'd1;
				end
			end
		end
	end

	// Parser state, updated once per request taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 3'd0;
			chip_q  <= 4'd0;
			hold_q  <= 8'd0;
			crc_q   <= PEC_SEED;
			err_q   <= 1'b0;
			group_q <= 2'd0;
			done_q  <= 1'b0;
		end else if (step) begin
			pos_q   <= pos_d;
			chip_q  <= chip_d;
			hold_q  <= hold_d;
			crc_q   <= crc_d;
			err_q   <= err_d;
			group_q <= group0;
			done_q  <= done_d;
		end
	end

endmodule

// ===== design/cell_voltage_readback_pec_check_top.sv =====
// ----------------------------------------------------------------------------
// cell_voltage_readback_pec_check_top
// Checks the bytes of a cell voltage register group readback from a chain of
// monitor chips, emitting cell codes and per-chip CRC-15 PEC results.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while in_stall is low. A byte
// is taken into the input register, the parse step forms its result from there,
// and the result register takes that result when the byte moves on. The parser
// state (byte position, chip counter, CRC remainder) updates as each byte moves
// on, so bytes can follow back to back. A stall on the result side holds the
// input register, and so stalls the input channel, only when the held byte
// yields a result and the result register still holds one that is not taken.
// Set chip_count through the register port while no request is in flight.
module cell_voltage_readback_pec_check_top
	import cvrpc_pkg::*;
#(
	parameter int MAX_CHIPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        first_byte,
	input  logic [1:0]  register_group,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [3:0]  chip_index,
	output logic [3:0]  cell_index,
	output logic [15:0] cell_code,
	output logic        pec_ok,
	output logic        any_error,
	output logic        last
);

	logic [4:0] chip_count;
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       first_byte_s1;
	logic [1:0] register_group_s1;
	logic       advance;
	logic       res_valid;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;

	cvrpc_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.chip_count (chip_count)
	);

	cvrpc_parse #(
		.MAX_CHIPS (MAX_CHIPS)
	) u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.rx_byte        (rx_byte_s1),
		.first_byte     (first_byte_s1),
		.register_group (register_group_s1),
		.chip_count     (chip_count),
		.res_valid      (res_valid),
		.res            (res)
	);

	// The held byte moves on unless it yields a result and the output is blocked.
	assign advance  = valid_s1 && (!res_valid || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			rx_byte_s1        <= rx_byte;
			first_byte_s1     <= first_byte;
			register_group_s1 <= register_group;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = out_q.kind;
	assign chip_index = out_q.chip_index;
	assign cell_index = out_q.cell_index;
	assign cell_code  = out_q.cell_code;
	assign pec_ok     = out_q.pec_ok;
	assign any_error  = out_q.any_error;
	assign last       = out_q.last;

endmodule

// ===== test/tb_cell_voltage_readback_pec_check_top.sv =====
// ----------------------------------------------------------------------------
// tb_cell_voltage_readback_pec_check_top
// Self-checking bench for the cell voltage readback PEC checker. A short table
// of hand-picked bytes comes first, then random chain readbacks under several
// chip-count settings. Table rows carry their own expected results; a local
// byte parser predicts the rest, and each delivered result is compared in order.
// ----------------------------------------------------------------------------
module tb_cell_voltage_readback_pec_check_top
	import cvrpc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_CHIPS_TB = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 10;
	localparam int PHASE_BYTES = 85;
	localparam logic [15:0] CRC_POLY = 16'h4599;
	localparam logic [15:0] CRC_SEED = 16'd16;
	localparam logic [2:0] CHIP_COUNT_ADDR = 3'(4 * int'(REG_CHIP_COUNT));

	// Where a table byte comes from: typed in, or taken from the running PEC.
	typedef enum logic [1:0] {
		SRC_TABLE,
		SRC_PEC_HIGH,
		SRC_PEC_LOW,
		SRC_PEC_BROKEN
	} byte_src_e;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic [1:0] grp;
		byte_src_e  src;
		logic       pinned;
		result_t    res;
	} directed_row_t;

	localparam int DIRECTED_LEN = 27;

	// Runs with the reset chip count of one.
	localparam directed_row_t DIRECTED [DIRECTED_LEN] = '{
		// No start marker after reset: parsed as group A.
		'{8'h00, 1'b0, 2'd0, SRC_TABLE, 1'b0, '0},
		'{8'hff, 1'b0, 2'd0, SRC_TABLE, 1'b1, '{KIND_CELL, 4'd0, 4'd0, 16'hff00, 1'b0, 1'b0, 1'b0}},
		'{8'hff, 1'b0, 2'd0, SRC_TABLE, 1'b0, '0},
		'{8'h00, 1'b0, 2'd0, SRC_TABLE, 1'b1, '{KIND_CELL, 4'd0, 4'd1, 16'h00ff, 1'b0, 1'b0, 1'b0}},
		'{8'h34, 1'b0, 2'd0, SRC_TABLE, 1'b0, '0},
		'{8'h12, 1'b0, 2'd0, SRC_TABLE, 1'b1, '{KIND_CELL, 4'd0, 4'd2, 16'h1234, 1'b0, 1'b0, 1'b0}},
		// Corrupted PEC sets the sticky error.
		'{8'h00, 1'b0, 2'd0, SRC_PEC_HIGH, 1'b0, '0},
		'{8'h00, 1'b0, 2'd0, SRC_PEC_BROKEN, 1'b1, '{KIND_PEC, 4'd0, 4'd0, 16'h0000, 1'b0, 1'b1, 1'b1}},
		// Trailing byte after the last chip is dropped.
		'{8'haa, 1'b0, 2'd0, SRC_TABLE, 1'b0, '0},
		// Group D start keeps the error flag.
		'{8'h00, 1'b1, 2'd3, SRC_TABLE, 1'b0, '0},
		'{8'h00, 1'b0, 2'd3, SRC_TABLE, 1'b1, '{KIND_CELL, 4'd0, 4'd9, 16'h0000, 1'b0, 1'b1, 1'b0}},
		'{8'h7f, 1'b0, 2'd3, SRC_TABLE, 1'b0, '0},
		'{8'h80, 1'b0, 2'd3, SRC_TABLE, 1'b1, '{KIND_CELL, 4'd0, 4'd10, 16'h807f, 1'b0, 1'b1, 1'b0}},
		'{8'hff, 1'b0, 2'd3, SRC_TABLE, 1'b0, '0},
		'{8'hff, 1'b0, 2'd3, SRC_TABLE, 1'b1, '{KIND_CELL, 4'd0, 4'd11, 16'hffff, 1'b0, 1'b1, 1'b0}},
		'{8'h00, 1'b0, 2'd3, SRC_PEC_HIGH, 1'b0, '0},
		'{8'h00, 1'b0, 2'd3, SRC_PEC_LOW, 1'b1, '{KIND_PEC, 4'd0, 4'd0, 16'h0000, 1'b1, 1'b1, 1'b1}},
		// Group A start clears the error flag.
		'{8'h55, 1'b1, 2'd0, SRC_TABLE, 1'b0, '0},
		'{8'h01, 1'b0, 2'd0, SRC_TABLE, 1'b1, '{KIND_CELL, 4'd0, 4'd0, 16'h0155, 1'b0, 1'b0, 1'b0}},
		// Restart in the middle of a frame, now group B.
		'{8'h80, 1'b1, 2'd1, SRC_TABLE, 1'b0, '0},
		'{8'h00, 1'b0, 2'd1, SRC_TABLE, 1'b1, '{KIND_CELL, 4'd0, 4'd3, 16'h0080, 1'b0, 1'b0, 1'b0}},
		'{8'h5a, 1'b0, 2'd1, SRC_TABLE, 1'b0, '0},
		'{8'ha5, 1'b0, 2'd1, SRC_TABLE, 1'b1, '{KIND_CELL, 4'd0, 4'd4, 16'ha55a, 1'b0, 1'b0, 1'b0}},
		'{8'h3c, 1'b0, 2'd1, SRC_TABLE, 1'b0, '0},
		'{8'hc3, 1'b0, 2'd1, SRC_TABLE, 1'b1, '{KIND_CELL, 4'd0, 4'd5, 16'hc33c, 1'b0, 1'b0, 1'b0}},
		'{8'h00, 1'b0, 2'd1, SRC_PEC_HIGH, 1'b0, '0},
		'{8'h00, 1'b0, 2'd1, SRC_PEC_LOW, 1'b1, '{KIND_PEC, 4'd0, 4'd0, 16'h0000, 1'b1, 1'b0, 1'b1}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        first_byte = 1'b0;
	logic [1:0]  register_group = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [3:0]  chip_index;
	logic [3:0]  cell_index;
	logic [15:0] cell_code;
	logic        pec_ok;
	logic        any_error;
	logic        last;

	// Predicted parser state, mirrored from the block.
	logic [2:0]  frame_pos = '0;
	logic [3:0]  chip_at = '0;
	logic [7:0]  low_hold = '0;
	logic [15:0] run_crc = CRC_SEED;
	logic        sticky_err = 1'b0;
	logic [1:0]  group_at = '0;
	logic        chain_done = 1'b0;
	logic [4:0]  chips_cfg = 5'd1;

	result_t parsed_results [$];
	bit      jitter = 1'b1;
	int      cycles = 0;
	int      mismatches = 0;
	int      bytes_taken = 0;
	int      bytes_ignored = 0;
	int      cells_seen = 0;
	int      pecs_seen = 0;
	int      pecs_bad = 0;

	cell_voltage_readback_pec_check_top #(
		.MAX_CHIPS(MAX_CHIPS_TB)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.first_byte(first_byte),
		.register_group(register_group),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.chip_index(chip_index),
		.cell_index(cell_index),
		.cell_code(cell_code),
		.pec_ok(pec_ok),
		.any_error(any_error),
		.last(last)
	);

	always #5 clk = ~clk;

	// CRC-15 remainder after one more byte, table entry built bit by bit.
	function automatic logic [15:0] crc15_step(input logic [15:0] rem, input logic [7:0] data);
		logic [15:0] t;
		t = (((rem >> 7) ^ {8'h00, data}) & 16'h00ff) << 7;
		repeat (8) t = t[14] ? ((t << 1) ^ CRC_POLY) : (t << 1);
		return (rem << 8) ^ t;
	endfunction

	// Chips in the chain after clamping the configured count.
	function automatic int eff_chips();
		int n;
		int lim;
		n = int'(chips_cfg);
		lim = (MAX_CHIPS_TB < 16) ? MAX_CHIPS_TB : 16;
		if (lim < 1) lim = 1;
		if (n < 1) n = 1;
		if (n > lim) n = lim;
		return n;
	endfunction

	// Byte parser: advances the predicted state and yields at most one result.
	task automatic parse_byte(input logic [7:0] b, input logic f, input logic [1:0] g,
			output bit took, output bit has_res, output result_t res);
		logic [15:0] rcvd;
		logic [15:0] calc;
		bit at_end;
		took = 1'b0;
		has_res = 1'b0;
		res = '0;
		if (f) begin
			frame_pos = '0;
			chip_at = '0;
			run_crc = CRC_SEED;
			chain_done = 1'b0;
			group_at = g;
			if (g == 2'd0) sticky_err = 1'b0;
		end
		if (chain_done) return;
		took = 1'b1;
		if (frame_pos < POS_PEC_HIGH) begin
			run_crc = crc15_step(run_crc, b);
			if (!frame_pos[0]) begin
				low_hold = b;
			end else begin
				has_res = 1'b1;
				res.kind = KIND_CELL;
				res.chip_index = chip_at;
				res.cell_index = 4'({2'b00, group_at} * 4'd3 + {2'b00, frame_pos[2:1]});
				res.cell_code = {b, low_hold};
				res.any_error = sticky_err;
			end
			frame_pos = frame_pos + 3'd1;
		end else if (frame_pos == POS_PEC_HIGH) begin
			low_hold = b;
			frame_pos = POS_PEC_LOW;
		end else begin
			rcvd = {low_hold, b};
			calc = {run_crc[14:0], 1'b0};
			at_end = (int'(chip_at) + 1) >= eff_chips();
			if (rcvd != calc) sticky_err = 1'b1;
			has_res = 1'b1;
			res.kind = KIND_PEC;
			res.chip_index = chip_at;
			res.pec_ok = (rcvd == calc);
			res.any_error = sticky_err;
			res.last = at_end;
			frame_pos = '0;
			run_crc = CRC_SEED;
			if (at_end) chain_done = 1'b1;
			else chip_at = chip_at + 4'd1;
		end
	endtask

	// Offer one byte request, wait for it to be taken, then predict its result.
	task automatic push_byte(input logic [7:0] b, input logic f, input logic [1:0] g,
			input bit pinned = 1'b0, input result_t pinned_res = '0);
		bit took;
		bit has_res;
		result_t res;
		while (jitter && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		first_byte <= f;
		register_group <= g;
		do @(posedge clk); while (in_stall);
		parse_byte(b, f, g, took, has_res, res);
		if (took) bytes_taken++;
		else bytes_ignored++;
		if (has_res) parsed_results.push_back(pinned ? pinned_res : res);
	endtask

	// Stop sending and let every predicted result drain out of the block.
	task automatic drain_requests();
		in_valid <= 1'b0;
		while (parsed_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One chain readback: mostly well formed, sometimes too long, cut short or noise.
	task automatic run_readback();
		logic [1:0] grp;
		logic [15:0] code;
		logic [15:0] pec;
		int mode;
		int total;
		int stop_at;
		grp = 2'($urandom_range(3));
		mode = $urandom_range(99);
		code = '0;
		pec = '0;
		if (mode >= 93) begin
			repeat ($urandom_range(12, 1))
				push_byte(8'($urandom), $urandom_range(7) == 0, 2'($urandom_range(3)));
			return;
		end
		total = 8 * (eff_chips() + ((mode >= 75 && mode < 85) ? 1 : 0));
		stop_at = (mode >= 85) ? $urandom_range(total - 1, 1) : total;
		for (int k = 0; k < stop_at; k++) begin
			case (k % 8)
				0, 2, 4: begin
					case ($urandom_range(7))
						0: code = 16'h0000;
						1: code = 16'hffff;
						default: code = 16'($urandom);
					endcase
					push_byte(code[7:0], k == 0, grp);
				end
				1, 3, 5: begin
					push_byte(code[15:8], 1'b0, grp);
				end
				6: begin
					pec = {run_crc[14:0], 1'b0};
					if ($urandom_range(99) < 12) pec = pec ^ (16'h0001 << $urandom_range(15));
					push_byte(pec[15:8], 1'b0, grp);
				end
				default: begin
					push_byte(pec[7:0], 1'b0, grp);
				end
			endcase
		end
	endtask

	function automatic void note_mismatch(input string what, input result_t want,
			input result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch (%s) at cycle %0d", what, cycles);
			$display("  expected kind=%0d chip=%0d cell=%0d code=%h ok=%0d err=%0d last=%0d",
				want.kind, want.chip_index, want.cell_index, want.cell_code,
				want.pec_ok, want.any_error, want.last);
			$display("  actual   kind=%0d chip=%0d cell=%0d code=%h ok=%0d err=%0d last=%0d",
				got.kind, got.chip_index, got.cell_index, got.cell_code,
				got.pec_ok, got.any_error, got.last);
		end
	endfunction

	// Result side backpressure.
	always @(posedge clk) begin
		out_stall <= jitter && ($urandom_range(99) < 13);
	end

	// Compare each delivered result with the oldest prediction.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {kind, chip_index, cell_index, cell_code, pec_ok, any_error, last};
			if (got.kind == KIND_PEC) begin
				pecs_seen++;
				if (!got.pec_ok) pecs_bad++;
			end else begin
				cells_seen++;
			end
			if (parsed_results.size() == 0) begin
				note_mismatch("no result expected", '0, got);
			end else begin
				want = parsed_results.pop_front();
				if (got !== want) note_mismatch("wrong field", want, got);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d results outstanding",
				cycles, parsed_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		directed_row_t row;
		logic [7:0] b;
		logic [15:0] pec_now;
		logic [4:0] chip_settings [8];
		int phase_start;
		bit paused_once;

		chip_settings = '{5'd16, 5'd0, 5'd31, 5'd5, 5'd1, 5'd17, 5'd2, 5'd9};
		chip_settings[7] = 5'($urandom_range(16, 1));
		paused_once = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table with the reset chip count.
		for (int i = 0; i < DIRECTED_LEN; i++) begin
			row = DIRECTED[i];
			pec_now = {run_crc[14:0], 1'b0};
			case (row.src)
				SRC_PEC_HIGH: b = pec_now[15:8];
				SRC_PEC_LOW: b = pec_now[7:0];
				SRC_PEC_BROKEN: b = pec_now[7:0] ^ 8'h01;
				default: b = row.data;
			endcase
			push_byte(b, row.first, row.grp, row.pinned, row.res);
		end

		// Random readbacks under each chip-count setting, written while idle.
		for (int p = 0; p < 8; p++) begin
			drain_requests();
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= CHIP_COUNT_ADDR;
			pwdata <= 32'(chip_settings[p]);
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			chips_cfg = chip_settings[p];
			// One phase runs with no idling on either side.
			jitter = (p != 3);
			phase_start = bytes_taken;
			while (bytes_taken - phase_start < PHASE_BYTES) begin
				run_readback();
				if (p == 1 && !paused_once) begin
					drain_requests();
					paused_once = 1'b1;
				end
			end
		end

		drain_requests();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d parsed bytes and %0d trailing bytes over 8 chip-count settings.",
			bytes_taken, bytes_ignored);
		$display("Checked %0d cell codes and %0d PEC results (%0d mismatched PECs).",
			cells_seen, pecs_seen, pecs_bad);
		if (mismatches == 0 && parsed_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
